### hdl/base_limit_byte_lane_memory_access_assert.svh
// Assertion macros shared by the byte-lane memory access block.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef BASE_LIMIT_BYTE_LANE_MEMORY_ACCESS_ASSERT_SVH
`define BASE_LIMIT_BYTE_LANE_MEMORY_ACCESS_ASSERT_SVH

// An implication checked at every clock edge outside reset.
`define BLBMA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define BLBMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A condition that holds at every clock edge outside reset.
`define BLBMA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

### hdl/blbma_pkg.sv
// Package of the byte-lane memory access block: types, codes and fixed widths.
// Used by the lane memory and by the top level.
package blbma_pkg;

    localparam int CFG_W    = 17;  // width of base and limit registers
    localparam int PHYS_W   = 18;  // physical byte address of an in-bounds access
    localparam int IDX_W    = PHYS_W - 2;
    localparam int ATIME_W  = 8;
    localparam int TIME_W   = 9;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;

    localparam logic [1:0] SIZE_BAD = 2'd3;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_TIME  = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OOB  = 2'd1;
    localparam logic [1:0] STATUS_SIZE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEND
    } t_state;

    // One access presented to the lane memory.
    typedef struct packed {
        logic             wr_en;
        logic [1:0]       offset;
        logic [1:0]       size_code;
        logic [IDX_W-1:0] word_idx;
        logic [IDX_W-1:0] word_idx_next;
        logic [31:0]      wdata;
    } t_mem_req;

endpackage

### hdl/blbma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module blbma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/blbma_lane_mem.sv
// Four byte-lane memories with the lane routing of unaligned accesses.
// Depends on blbma_pkg and blbma_ram.
module blbma_lane_mem
    import blbma_pkg::*;
#(
    parameter int MEM_WORDS = 16384
) (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [AW-1:0] lane_addr  [4];
    logic          lane_we    [4];
    logic [7:0]    lane_wdata [4];
    logic [7:0]    lane_rdata [4];
    logic [1:0]    r_off;
    logic [1:0]    r_size;
    logic [2:0]    wr_count;
    logic [2:0]    rd_count;

    // Lane l carries byte (l - offset) mod 4 of the access; lanes below the
    // offset belong to the following word.
    always_comb begin
        logic [1:0] k;
        wr_count = 3'b001 << i_req.size_code;
        for (int l = 0; l < 4; l++) begin
            k = 2'(l) - i_req.offset;
            lane_addr[l]  = (2'(l) >= i_req.offset) ? AW'(i_req.word_idx)
                                                    : AW'(i_req.word_idx_next);
            lane_we[l]    = i_req.wr_en && ({1'b0, k} < wr_count);
            lane_wdata[l] = i_req.wdata[8*k +: 8];
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        blbma_ram #(
            .WIDTH(8),
            .DEPTH(MEM_WORDS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (lane_we[l]),
            .i_waddr(lane_addr[l]),
            .i_wdata(lane_wdata[l]),
            .i_raddr(lane_addr[l]),
            .o_rdata(lane_rdata[l])
        );
    end

    // Offset and size are registered alongside the registered read data.
    always_ff @(posedge i_clk) begin
        r_off  <= i_req.offset;
        r_size <= i_req.size_code;
    end

    always_comb begin
        logic [1:0] lane;
        rd_count = 3'b001 << r_size;
        o_rdata  = '0;
        for (int k = 0; k < 4; k++) begin
            lane = r_off + 2'(k);
            if (3'(k) < rd_count) begin
                o_rdata[8*k +: 8] = lane_rdata[lane];
            end
        end
    end

endmodule

### hdl/base_limit_byte_lane_memory_access.sv
// Top level of the base-and-limit relocating byte-lane load/store unit.
// Depends on blbma_pkg, blbma_lane_mem and the assertion macro header.
//
// Each input transaction is a load or a store of 1, 2 or 4 bytes at a logical
// address. The access is allowed when address plus byte count does not exceed
// the window limit; it then lands at address plus base offset in a little-endian
// memory built from four byte-lane RAMs, so an access that straddles two words
// still takes a single memory access. A size code of 3 counts eight bytes in the
// bound check and is reported as unsupported when it passes. Every input
// transaction yields exactly one output transaction with the zero-extended load
// data (zero for stores and errors), a status, the misaligned flag and the
// access time (doubled when misaligned, zero on error). A load passes through
// the bound check and memory issue, the read data return and the move to the
// output register; a store or an error skips the read data step. The control
// handles one transaction at a time, so no new transaction is taken before
// the last one has moved to the output register. The next transaction is
// accepted in the cycle after the result moves to the output register, even
// while that result waits for the downstream side; the one after that waits
// until the output register is free. Memory contents are undefined until
// written; there is no clearing pass after reset. A write to base_offset or
// window_limit is ignored when it would let base plus limit exceed MEM_BYTES.
`include "base_limit_byte_lane_memory_access_assert.svh"
module base_limit_byte_lane_memory_access
    import blbma_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel.
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // address [31:0], size_code [33:32], store_data [65:34], zero [71:66]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // func [0]: 0 load, 1 store
    input  logic                i_s_tuser,
    // Output channel.
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // load_data [31:0], time_taken [40:32], misaligned [41], zero [47:42]
    output logic [M_DATA_W-1:0] o_m_tdata,
    // status [1:0]: 0 ok, 1 out of bounds, 2 unsupported size
    output logic [1:0]          o_m_tuser,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    localparam int          MEM_WORDS = (MEM_BYTES + 3) / 4;
    localparam logic [31:0] MEM_LIM   = 32'(MEM_BYTES);

    // Control and configuration state.
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_base;
    logic [CFG_W-1:0]   r_limit;
    logic [ATIME_W-1:0] r_atime;
    logic               r_m_tvalid, n_m_tvalid;

    // Captured transaction and pending result.
    logic               r_func;
    logic [31:0]        r_addr;
    logic [1:0]         r_size;
    logic [31:0]        r_sdata;
    logic [31:0]        r_res_data, n_res_data;
    logic [1:0]         r_res_status, n_res_status;
    logic [TIME_W-1:0]  r_res_time, n_res_time;
    logic               r_res_mis, n_res_mis;
    logic [M_DATA_W-1:0] r_m_tdata;
    logic [1:0]         r_m_tuser;

    // Datapath of the check stage.
    logic [32:0]        end_addr;
    logic               out_of_bounds;
    logic [PHYS_W-1:0]  phys;
    logic [PHYS_W-1:0]  phys_next_word;
    logic               mis;
    logic               out_free;
    logic               base_ok;
    logic               limit_ok;
    t_mem_req           mem_req;
    logic [31:0]        mem_rdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_m_tvalid || i_m_tready;

    // Bound check over the full 33-bit sum, and relocation. An in-bounds
    // address is below the 17-bit limit, so its low bits suffice for phys.
    assign end_addr       = {1'b0, r_addr} + (33'd1 << r_size);
    assign out_of_bounds  = end_addr > {16'd0, r_limit};
    assign phys           = PHYS_W'(r_addr[CFG_W-1:0]) + PHYS_W'(r_base);
    assign phys_next_word = PHYS_W'(r_addr[CFG_W-1:0]) + PHYS_W'(r_base)
                          + PHYS_W'(4);

    always_comb begin
        case (r_size)
            2'd1:    mis = phys[0];
            2'd2:    mis = phys[1:0] != 2'd0;
            default: mis = 1'b0;
        endcase
    end

    always_comb begin
        mem_req.wr_en         = (r_state == S_EXEC) && r_func && !out_of_bounds
                              && (r_size != SIZE_BAD);
        mem_req.offset        = phys[1:0];
        mem_req.size_code     = r_size;
        mem_req.word_idx      = phys[PHYS_W-1:2];
        mem_req.word_idx_next = phys_next_word[PHYS_W-1:2];
        mem_req.wdata         = r_sdata;
    end

    blbma_lane_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_lane_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(mem_rdata)
    );

    // Next state and result.
    always_comb begin
        n_state      = r_state;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_res_time   = r_res_time;
        n_res_mis    = r_res_mis;
        n_m_tvalid   = r_m_tvalid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_data = '0;
                if (out_of_bounds) begin
                    n_res_status = STATUS_OOB;
                    n_res_time   = '0;
                    n_res_mis    = 1'b0;
                    n_state      = S_SEND;
                end else if (r_size == SIZE_BAD) begin
                    n_res_status = STATUS_SIZE;
                    n_res_time   = '0;
                    n_res_mis    = 1'b0;
                    n_state      = S_SEND;
                end else begin
                    n_res_status = STATUS_OK;
                    n_res_time   = mis ? {r_atime, 1'b0} : {1'b0, r_atime};
                    n_res_mis    = mis;
                    n_state      = r_func ? S_SEND : S_READ;
                end
            end
            S_READ: begin
                n_res_data = mem_rdata;
                n_state    = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_func  <= i_s_tuser;
            r_addr  <= i_s_tdata[31:0];
            r_size  <= i_s_tdata[33:32];
            r_sdata <= i_s_tdata[65:34];
        end
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_res_time   <= n_res_time;
        r_res_mis    <= n_res_mis;
        if (r_state == S_SEND && out_free) begin
            r_m_tdata <= {6'd0, r_res_mis, r_res_time, r_res_data};
            r_m_tuser <= r_res_status;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // Configuration registers. Base and limit together must stay within the
    // memory, so a write that would break that is dropped.
    assign base_ok  = (32'(i_cfg_wdata) <= MEM_LIM)
                   && (32'(i_cfg_wdata) + 32'(r_limit) <= MEM_LIM);
    assign limit_ok = (32'(i_cfg_wdata) <= MEM_LIM)
                   && (32'(i_cfg_wdata) + 32'(r_base) <= MEM_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= CFG_W'(MEM_BYTES);
            r_atime <= ATIME_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE: begin
                    if (base_ok) begin
                        r_base <= i_cfg_wdata;
                    end
                end
                REG_LIMIT: begin
                    if (limit_ok) begin
                        r_limit <= i_cfg_wdata;
                    end
                end
                REG_TIME: begin
                    r_atime <= i_cfg_wdata[ATIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The window never reaches past the end of the memory.
    `BLBMA_ASSERT_ALWAYS(a_window_fits, i_clk, i_rst_n,
        32'(r_base) + 32'(r_limit) <= MEM_LIM, "base plus limit exceeds memory")
    // An accepted transaction is checked in the very next cycle.
    `BLBMA_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready, r_state == S_EXEC, "accept did not start check")
    // Only loads wait for memory read data.
    `BLBMA_ASSERT_IMPL(a_read_is_load, i_clk, i_rst_n,
        r_state == S_READ, !r_func, "store entered the read state")
    // An error result carries neither data nor time nor misalignment.
    `BLBMA_ASSERT_IMPL(a_error_clean, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != STATUS_OK),
        o_m_tdata[41:0] == 42'd0, "error result carries payload")
    // A misaligned result always reports a doubled time.
    `BLBMA_ASSERT_IMPL(a_mis_time_even, i_clk, i_rst_n,
        o_m_tvalid && o_m_tdata[41], o_m_tdata[32] == 1'b0,
        "misaligned result with odd time")

endmodule
